// File: rtl/dcm_pkg.sv
// dcm_pkg: shared constants and codes for the duty cycle meter.
// No dependencies; compiled before the interfaces and the top level.
package dcm_pkg;

  // Parameter defaults
  localparam int TIME_BITS_DEF     = 32;
  localparam int FRACTION_BITS_DEF = 8;

  // Fixed field widths of the channel words
  localparam int IN_TIME_W = 32;
  localparam int DUTY_W    = 15;

  // Percent scale and the bits it takes
  localparam int PCT_SCALE = 100;
  localparam int PCT_BITS  = 7;

  // Event kind codes
  typedef enum logic {
    KIND_PIN    = 1'b0,
    KIND_REPORT = 1'b1
  } kind_t;

endpackage

// File: rtl/dcm_if.sv
// dcm_if: valid/ready channel interfaces for the duty cycle meter.
// Depends on dcm_pkg for the field widths.
interface dcm_in_if import dcm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [IN_TIME_W-1:0] time_us;
  logic                 pin_level;

  modport source (output valid, kind, time_us, pin_level, input ready);
  modport sink   (input valid, kind, time_us, pin_level, output ready);
endinterface

interface dcm_out_if import dcm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] duty_percent_q8;
  logic              empty_window;

  modport source (output valid, duty_percent_q8, empty_window, input ready);
  modport sink   (input valid, duty_percent_q8, empty_window, output ready);
endinterface

// File: rtl/duty_cycle_meter.sv
// duty_cycle_meter: high-time share of a digital input between reports.
// Depends on dcm_pkg and the channel interfaces in dcm_if.sv.
//
// Pin words only update the held level, the edge time and the on-time
// sum. A report word closes the window; the first report only primes it. A
// later report that needs the divider yields one result word through a
// setup step that forms on_time * 100, a restoring divider that produces
// one quotient bit per cycle, a step to clamp and a step to load the output
// register. An empty or fully high window skips the divider and the clamp,
// and goes from the setup step straight to the output step. The input side
// is held off from a report until its result word is loaded. The output
// register lets a pin word or a report be taken while a result still waits;
// a finished result waits in the last step until the output register is
// free. Time differences wrap modulo 2^TIME_BITS and the on-time saturates
// at 2^TIME_BITS - 1.
module duty_cycle_meter import dcm_pkg::*; #(
  parameter int TIME_BITS     = TIME_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  dcm_in_if.sink    in_ch,
  dcm_out_if.source out_ch
);

  localparam int QB    = PCT_BITS + FRACTION_BITS;  // quotient bits
  localparam int NUM_W = TIME_BITS + PCT_BITS;       // on_time * 100
  localparam int N_W   = TIME_BITS + QB;             // dividend width
  localparam int CNT_W = $clog2(QB);
  localparam logic [QB-1:0] FULL = QB'(PCT_SCALE) << FRACTION_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_DIV,
    S_FIN,
    S_PUT
  } state_t;

  state_t               state_r, state_nxt;
  logic                 held_r, held_nxt;
  logic [TIME_BITS-1:0] last_r, last_nxt;
  logic [TIME_BITS-1:0] sum_r, sum_nxt;
  logic [TIME_BITS-1:0] start_r, start_nxt;
  logic                 primed_r, primed_nxt;
  logic [TIME_BITS-1:0] on_r, on_nxt;
  logic [TIME_BITS-1:0] tot_r, tot_nxt;
  logic [TIME_BITS-1:0] rem_r, rem_nxt;
  logic [QB-1:0]        quo_r, quo_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DUTY_W-1:0]    duty_r, duty_nxt;
  logic                 empty_r, empty_nxt;
  logic                 ovalid_r, ovalid_nxt;
  logic [DUTY_W-1:0]    oduty_r, oduty_nxt;
  logic                 oempty_r, oempty_nxt;

  logic                 in_take;
  logic                 slot_free;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] since_edge;
  logic [NUM_W-1:0]     on_ext;
  logic [NUM_W-1:0]     num;
  logic [N_W-1:0]       dividend;
  logic [TIME_BITS:0]   trial;
  logic [TIME_BITS:0]   trial_diff;
  logic                 trial_ge;

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
  endfunction

  // Handshake
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign slot_free   = !ovalid_r || out_ch.ready;

  assign out_ch.valid           = ovalid_r;
  assign out_ch.duty_percent_q8 = oduty_r;
  assign out_ch.empty_window    = oempty_r;

  // Event time and elapsed time since the last edge
  assign now        = TIME_BITS'(in_ch.time_us);
  assign since_edge = now - last_r;

  // on_time * 100 as shift-adds, then scaled by the fraction bits
  assign on_ext   = NUM_W'(on_r);
  assign num      = (on_ext << 6) + (on_ext << 5) + (on_ext << 2);
  assign dividend = N_W'(num) << FRACTION_BITS;

  // One restoring divide step
  assign trial      = {rem_r, quo_r[QB-1]};
  assign trial_ge   = (trial >= {1'b0, tot_r});
  assign trial_diff = trial - {1'b0, tot_r};

  // Next-state logic
  always_comb begin
    state_nxt  = state_r;
    held_nxt   = held_r;
    last_nxt   = last_r;
    sum_nxt    = sum_r;
    start_nxt  = start_r;
    primed_nxt = primed_r;
    on_nxt     = on_r;
    tot_nxt    = tot_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    cnt_nxt    = cnt_r;
    duty_nxt   = duty_r;
    empty_nxt  = empty_r;
    ovalid_nxt = ovalid_r;
    oduty_nxt  = oduty_r;
    oempty_nxt = oempty_r;

    if (ovalid_r && out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          if (in_ch.kind == KIND_PIN) begin
            // repeated level is ignored
            if (in_ch.pin_level != held_r) begin
              held_nxt = in_ch.pin_level;
              last_nxt = now;
              if (!in_ch.pin_level) begin
                sum_nxt = sat_add(sum_r, since_edge);
              end
            end
          end else begin
            on_nxt     = held_r ? sat_add(sum_r, since_edge) : sum_r;
            tot_nxt    = now - start_r;
            sum_nxt    = '0;
            last_nxt   = now;
            start_nxt  = now;
            primed_nxt = 1'b1;
            if (primed_r) begin
              state_nxt = S_SETUP;
            end
          end
        end
      end
      S_SETUP: begin
        if (tot_r == '0) begin
          duty_nxt  = '0;
          empty_nxt = 1'b1;
          state_nxt = S_PUT;
        end else if (on_r >= tot_r) begin
          duty_nxt  = DUTY_W'(FULL);
          empty_nxt = 1'b0;
          state_nxt = S_PUT;
        end else begin
          rem_nxt   = dividend[N_W-1:QB];
          quo_nxt   = dividend[QB-1:0];
          cnt_nxt   = '0;
          empty_nxt = 1'b0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt = trial_ge ? trial_diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
        quo_nxt = {quo_r[QB-2:0], trial_ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(QB - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        duty_nxt  = DUTY_W'((quo_r > FULL) ? FULL : quo_r);
        state_nxt = S_PUT;
      end
      S_PUT: begin
        if (slot_free) begin
          ovalid_nxt = 1'b1;
          oduty_nxt  = duty_r;
          oempty_nxt = empty_r;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      held_r   <= 1'b0;
      last_r   <= '0;
      sum_r    <= '0;
      start_r  <= '0;
      primed_r <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      held_r   <= held_nxt;
      last_r   <= last_nxt;
      sum_r    <= sum_nxt;
      start_r  <= start_nxt;
      primed_r <= primed_nxt;
      ovalid_r <= ovalid_nxt;
    end
    on_r     <= on_nxt;
    tot_r    <= tot_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    cnt_r    <= cnt_nxt;
    duty_r   <= duty_nxt;
    empty_r  <= empty_nxt;
    oduty_r  <= oduty_nxt;
    oempty_r <= oempty_nxt;
  end

  // Checks
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < tot_r))
    else $error("divider remainder not below window length");

  a_result_from_put: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovalid_r) |-> ($past(state_r) == S_PUT))
    else $error("result word raised outside the output step");

  a_empty_means_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && oempty_r) |-> (oduty_r == '0))
    else $error("empty window with nonzero duty");

  a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |=> !$past(in_take))
    else $error("input word taken while dividing");

endmodule
